>>> rtl/core/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int OFFSET_BITS       = 32;
    localparam int START_BITS        = 32;
    localparam int COUNT_BITS        = 16;
    localparam int LEN_BITS          = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int POS_BITS          = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CFG_DATA_BITS     = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_LOW     = 3'd0,
        CFG_PATTERN_HIGH    = 3'd1,
        CFG_MASK_LOW        = 3'd2,
        CFG_MASK_HIGH       = 3'd3,
        CFG_PATTERN_LENGTH  = 3'd4,
        CFG_FIND_MODE       = 3'd5,
        CFG_INSTANCE_WANTED = 3'd6
    } t_cfg_idx;

    // find_mode codes
    localparam logic MODE_FIND_ALL = 1'b0;
    localparam logic MODE_FIND_NTH = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
        logic       scan_end;
    } t_scan_in;

    typedef struct packed {
        logic                  match_found;
        logic [START_BITS-1:0] match_start;
        logic [COUNT_BITS-1:0] matches_seen;
    } t_scan_out;

endpackage

`default_nettype wire

>>> rtl/core/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// The result register loads at the edge that accepts the byte; while the output
// is stalled the result goes to a one-entry skid stage. Throughput: one byte per
// cycle while the skid is empty (o_in_stall is high while it is full); the window
// compare is a parallel masked equality over all lanes. Reset clears fill count,
// offset and counters and restores register defaults; window bytes are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scanner (
    input  wire                                logic i_clk,
    input  wire                                logic i_rst_n,
    // byte stream in
    input  wire                                logic i_in_valid,
    output logic                               o_in_stall,
    input  wire mbps_pkg::t_scan_in            i_in_data,
    // results out
    output logic                               o_out_valid,
    input  wire                                logic i_out_stall,
    output mbps_pkg::t_scan_out                o_out_data,
    // configuration writes
    input  wire                                logic i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mbps_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int NB = mbps_pkg::MAX_PATTERN_BYTES;

    // configuration
    logic [8*NB-1:0]                 r_pattern;
    logic [8*NB-1:0]                 r_mask;
    logic [4:0]                      r_pattern_length;
    logic                            r_find_mode;
    logic [mbps_pkg::COUNT_BITS-1:0] r_instance_wanted;

    // scan state
    logic [7:0]                      r_window [NB];
    logic [7:0]                      n_window [NB];
    logic [mbps_pkg::LEN_BITS-1:0]   r_fill;
    logic [mbps_pkg::LEN_BITS-1:0]   n_fill;
    logic [mbps_pkg::OFFSET_BITS-1:0] r_offset;
    logic [mbps_pkg::OFFSET_BITS-1:0] n_offset;
    logic [mbps_pkg::COUNT_BITS-1:0] r_count;
    logic [mbps_pkg::COUNT_BITS-1:0] n_count;
    logic                            r_done;
    logic                            n_done;

    // output register and skid
    logic                            r_out_valid;
    mbps_pkg::t_scan_out             r_out;
    logic                            r_skid_valid;
    mbps_pkg::t_scan_out             r_skid;

    logic                            in_acc;
    logic                            out_free;
    logic                            cfg_wr;
    logic [mbps_pkg::LEN_BITS-1:0]   len;
    logic [mbps_pkg::POS_BITS-1:0]   len_m1;
    logic [mbps_pkg::POS_BITS-1:0]   pos [NB];
    logic [NB-1:0]                   lane_ok;
    logic                            hit;
    logic                            report;
    logic                            region_clr;
    logic [mbps_pkg::OFFSET_BITS-1:0] start;
    mbps_pkg::t_scan_out             n_result;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc   = i_in_valid & ~r_skid_valid;
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign cfg_wr   = i_cfg_valid & o_cfg_ready;

    // clamp length into 1..MAX_PATTERN_BYTES
    always_comb begin
        if (r_pattern_length == 5'd0) begin
            len = mbps_pkg::LEN_BITS'(1);
        end else if (r_pattern_length > 5'(NB)) begin
            len = mbps_pkg::LEN_BITS'(NB);
        end else begin
            len = mbps_pkg::LEN_BITS'(r_pattern_length);
        end
        len_m1 = mbps_pkg::POS_BITS'(len - mbps_pkg::LEN_BITS'(1));
    end

    // shift in the new byte, newest at index 0
    always_comb begin
        n_window[0] = i_in_data.data_byte;
        for (int k = 1; k < NB; k++) begin
            n_window[k] = r_window[k-1];
        end
        if (r_fill < mbps_pkg::LEN_BITS'(NB)) begin
            n_fill = r_fill + mbps_pkg::LEN_BITS'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    // lane i of the pattern lines up with window byte len-1-i
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            pos[i] = len_m1 - mbps_pkg::POS_BITS'(i);
            if (mbps_pkg::LEN_BITS'(i) < len) begin
                lane_ok[i] = ((n_window[pos[i]] ^ r_pattern[8*i +: 8])
                              & r_mask[8*i +: 8]) == 8'h00;
            end else begin
                lane_ok[i] = 1'b1;
            end
        end
        hit = (n_fill >= len) && (&lane_ok);
    end

    always_comb begin
        n_count = r_count;
        if (hit && r_count != {mbps_pkg::COUNT_BITS{1'b1}}) begin
            n_count = r_count + mbps_pkg::COUNT_BITS'(1);
        end

        report = 1'b0;
        if (hit) begin
            if (r_find_mode == mbps_pkg::MODE_FIND_ALL) begin
                report = 1'b1;
            end else if (!r_done && r_instance_wanted != '0 &&
                         n_count == r_instance_wanted) begin
                report = 1'b1;
            end
        end

        start = r_offset - mbps_pkg::OFFSET_BITS'(len_m1);

        n_result.match_found  = report;
        n_result.match_start  = report ? mbps_pkg::START_BITS'(start) : '0;
        n_result.matches_seen = n_count;

        region_clr = i_in_data.region_end | i_in_data.scan_end;
        n_offset   = region_clr ? '0 : r_offset + mbps_pkg::OFFSET_BITS'(1);
        n_done     = r_done | (report && r_find_mode == mbps_pkg::MODE_FIND_NTH);
        if (i_in_data.scan_end) begin
            n_done = 1'b0;
        end
    end

    // window bytes beyond the fill count are never compared
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < NB; k++) begin
                r_window[k] <= n_window[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_offset <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else if (in_acc) begin
            r_fill   <= region_clr ? '0 : n_fill;
            r_offset <= n_offset;
            r_count  <= i_in_data.scan_end ? '0 : n_count;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern         <= '0;
            r_mask            <= '0;
            r_pattern_length  <= 5'd1;
            r_find_mode       <= mbps_pkg::MODE_FIND_ALL;
            r_instance_wanted <= mbps_pkg::COUNT_BITS'(1);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                mbps_pkg::CFG_PATTERN_LOW: begin
                    r_pattern[63:0] <= i_cfg_data;
                end
                mbps_pkg::CFG_PATTERN_HIGH: begin
                    r_pattern[127:64] <= i_cfg_data;
                end
                mbps_pkg::CFG_MASK_LOW: begin
                    r_mask[63:0] <= i_cfg_data;
                end
                mbps_pkg::CFG_MASK_HIGH: begin
                    r_mask[127:64] <= i_cfg_data;
                end
                mbps_pkg::CFG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[4:0];
                end
                mbps_pkg::CFG_FIND_MODE: begin
                    r_find_mode <= i_cfg_data[0];
                end
                mbps_pkg::CFG_INSTANCE_WANTED: begin
                    r_instance_wanted <= i_cfg_data[mbps_pkg::COUNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // result register with a one-entry skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

endmodule

`default_nettype wire
